### rtl/core/coordinate_rmsd_accumulator_defines.svh
// Assertion macros shared by the coordinate RMSD accumulator RTL.
`ifndef COORDINATE_RMSD_ACCUMULATOR_DEFINES_SVH
`define COORDINATE_RMSD_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define CRMSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define CRMSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CRMSD_ASSERT(label, clk, rst, prop, msg)

`define CRMSD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### rtl/core/crmsd_pkg.sv
// Types and constants of the coordinate RMSD accumulator.
package crmsd_pkg;

   localparam int COORD_BITS = 20;
   localparam int MAX_ATOMS  = 65536;

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int MAG_BITS   = COORD_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int DSQ_BITS   = SQ_BITS + 2;

   localparam int SUM_BITS   = 60;
   localparam int COUNT_BITS = 17;
   localparam int RMSD_BITS  = 21;
   localparam int WARN_BITS  = 21;

   localparam int ROOT_BITS  = SUM_BITS / 2;
   localparam int REM_BITS   = ROOT_BITS + 3;
   localparam int ALU_BITS   = REM_BITS + 1;
   localparam int STEP_BITS  = $clog2(SUM_BITS);

   localparam logic [COUNT_BITS-1:0] MAX_ATOMS_C  = COUNT_BITS'(MAX_ATOMS);
   localparam logic [WARN_BITS-1:0]  WARN_RESET_C = WARN_BITS'(5120);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ADD,
      ST_ACCUM,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

### rtl/core/coordinate_rmsd_accumulator.sv
// Coordinate RMSD accumulator: sums squared pair distances, then divides and takes the root.
// An item without last passes the square steps for x, y and z, then add and accumulate, then idle.
// An item with last goes on from accumulate through divide, root and done before its result shows.
// A new atom pair is accepted only back in idle; each uses the single shared squarer and accumulate path;
// the closing divide and root run bit-serially through one shared 34-bit subtractor.
// Reset is synchronous, active high: clears sum, count, overflow flag, output valid; limit is 5.0 A.
`include "coordinate_rmsd_accumulator_defines.svh"

module coordinate_rmsd_accumulator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [crmsd_pkg::COORD_BITS-1:0] req_model_x,
   input  logic signed [crmsd_pkg::COORD_BITS-1:0] req_model_y,
   input  logic signed [crmsd_pkg::COORD_BITS-1:0] req_model_z,
   input  logic signed [crmsd_pkg::COORD_BITS-1:0] req_ref_x,
   input  logic signed [crmsd_pkg::COORD_BITS-1:0] req_ref_y,
   input  logic signed [crmsd_pkg::COORD_BITS-1:0] req_ref_z,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [crmsd_pkg::RMSD_BITS-1:0]       rsp_rmsd,
   output logic [crmsd_pkg::COUNT_BITS-1:0]      rsp_atom_count,
   output logic                                  rsp_far_apart,
   output logic                                  rsp_overflow,
   input  logic                                  csr_wr_en,
   input  logic [crmsd_pkg::WARN_BITS-1:0]       csr_wr_data
);

   import crmsd_pkg::*;

   state_type state_ff, state_in;

   logic signed [COORD_BITS-1:0] mx_ff, my_ff, mz_ff, rx_ff, ry_ff, rz_ff;
   logic                         last_ff;

   logic [1:0]            axis_ff, axis_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [SQ_BITS-1:0]    prod_ff, prod_in;
   logic [DSQ_BITS-1:0]   dsq_ff, dsq_in;
   logic [SUM_BITS-1:0]   square_sum_ff, square_sum_in;
   logic [COUNT_BITS-1:0] pair_count_ff, pair_count_in;
   logic                  saturated_ff, saturated_in;
   logic [SUM_BITS-1:0]   sh_ff, sh_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [WARN_BITS-1:0]  warn_limit_ff, warn_limit_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [RMSD_BITS-1:0]  rsp_rmsd_ff;
   logic [COUNT_BITS-1:0] rsp_atom_count_ff;
   logic                  rsp_far_apart_ff, rsp_overflow_ff;

   logic                  req_accept;
   logic                  out_load;
   logic signed [COORD_BITS-1:0] sel_a, sel_b;
   logic signed [DIFF_BITS-1:0]  diff;
   logic [DIFF_BITS-1:0]  mag_full;
   logic [MAG_BITS-1:0]   mag;
   logic [SQ_BITS-1:0]    square;
   logic [SUM_BITS:0]     sum_wide;
   logic [SUM_BITS-1:0]   sum_upd;
   logic [COUNT_BITS-1:0] divisor;
   logic [ALU_BITS-1:0]   alu_a, alu_b;
   logic [ALU_BITS:0]     alu_diff;
   logic                  alu_ge;
   logic [REM_BITS-1:0]   alu_rem;
   logic [RMSD_BITS-1:0]  rmsd_val;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // squarer datapath: one axis per cycle
   always_comb begin
      case (axis_ff)
         2'd0: begin
            sel_a = mx_ff;
            sel_b = rx_ff;
         end
         2'd1: begin
            sel_a = my_ff;
            sel_b = ry_ff;
         end
         default: begin
            sel_a = mz_ff;
            sel_b = rz_ff;
         end
      endcase
      diff     = DIFF_BITS'(sel_a) - DIFF_BITS'(sel_b);
      mag_full = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
      mag      = mag_full[MAG_BITS-1:0];
      square   = SQ_BITS'(mag) * SQ_BITS'(mag);
   end

   // saturating accumulate of one pair's squared distance
   always_comb begin
      sum_wide = {1'b0, square_sum_ff} + (SUM_BITS + 1)'(dsq_ff);
      sum_upd  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
      divisor  = (pair_count_ff == '0) ? COUNT_BITS'(1) : pair_count_ff;
   end

   // shared compare/subtract unit for restoring divide and digit-by-digit root
   always_comb begin
      if (state_ff == ST_SQRT) begin
         alu_a = {rem_ff[REM_BITS-2:0], sh_ff[SUM_BITS-1:SUM_BITS-2]};
         alu_b = ALU_BITS'({root_ff, 2'b01});
      end else begin
         alu_a = {rem_ff, sh_ff[SUM_BITS-1]};
         alu_b = ALU_BITS'(divisor);
      end
      alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
      alu_ge   = !alu_diff[ALU_BITS];
      alu_rem  = alu_ge ? alu_diff[REM_BITS-1:0] : alu_a[REM_BITS-1:0];
      rmsd_val = (|root_ff[ROOT_BITS-1:RMSD_BITS]) ? {RMSD_BITS{1'b1}}
                                                  : root_ff[RMSD_BITS-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      dsq_in        = dsq_ff;
      square_sum_in = square_sum_ff;
      pair_count_in = pair_count_ff;
      saturated_in  = saturated_ff;
      sh_in         = sh_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      warn_limit_in = csr_wr_en ? csr_wr_data : warn_limit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            axis_in = 2'd0;
            if (req_accept) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            prod_in = square;
            dsq_in  = (axis_ff == 2'd0) ? '0 : dsq_ff + DSQ_BITS'(prod_ff);
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            dsq_in   = dsq_ff + DSQ_BITS'(prod_ff);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // drop the pair once the count is full
            if (pair_count_ff == MAX_ATOMS_C) begin
               saturated_in = 1'b1;
               sh_in        = square_sum_ff;
            end else begin
               square_sum_in = sum_upd;
               pair_count_in = pair_count_ff + COUNT_BITS'(1);
               sh_in         = sum_upd;
               if (sum_wide[SUM_BITS]) begin
                  saturated_in = 1'b1;
               end
            end
            rem_in  = '0;
            step_in = '0;
            state_in = last_ff ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            sh_in   = {sh_ff[SUM_BITS-2:0], alu_ge};
            rem_in  = alu_rem;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sh_in   = {sh_ff[SUM_BITS-3:0], 2'b00};
            rem_in  = alu_rem;
            root_in = {root_ff[ROOT_BITS-2:0], alu_ge};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               out_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               square_sum_in = '0;
               pair_count_in = '0;
               saturated_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         axis_ff       <= '0;
         step_ff       <= '0;
         square_sum_ff <= '0;
         pair_count_ff <= '0;
         saturated_ff  <= 1'b0;
         warn_limit_ff <= WARN_RESET_C;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         step_ff       <= step_in;
         square_sum_ff <= square_sum_in;
         pair_count_ff <= pair_count_in;
         saturated_ff  <= saturated_in;
         warn_limit_ff <= warn_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mx_ff   <= req_model_x;
         my_ff   <= req_model_y;
         mz_ff   <= req_model_z;
         rx_ff   <= req_ref_x;
         ry_ff   <= req_ref_y;
         rz_ff   <= req_ref_z;
         last_ff <= req_last;
      end
      prod_ff <= prod_in;
      dsq_ff  <= dsq_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (out_load) begin
         rsp_rmsd_ff       <= rmsd_val;
         rsp_atom_count_ff <= pair_count_ff;
         rsp_far_apart_ff  <= (rmsd_val > warn_limit_ff);
         rsp_overflow_ff   <= saturated_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rmsd       = rsp_rmsd_ff;
   assign rsp_atom_count = rsp_atom_count_ff;
   assign rsp_far_apart  = rsp_far_apart_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   `CRMSD_ASSERT(a_valid_from_done, clock, reset, $rose(rsp_valid) |-> $past(state_ff) == ST_DONE, "result valid rose outside the done step")
   `CRMSD_ASSERT(a_count_bound, clock, reset, pair_count_ff <= MAX_ATOMS_C, "pair count exceeded its ceiling")
   `CRMSD_ASSERT(a_div_rem, clock, reset, state_ff == ST_DIV |-> rem_ff < REM_BITS'(divisor), "divide remainder not below divisor")
   `CRMSD_ASSERT(a_count_nonzero, clock, reset, $rose(rsp_valid) |-> rsp_atom_count != '0, "result with zero atom count")

endmodule
